### rtl/rotate_vector_about_axis_top_macros.svh
// Assertion macros for the vector rotation block.
`ifndef ROTATE_VECTOR_ABOUT_AXIS_TOP_MACROS_SVH
`define ROTATE_VECTOR_ABOUT_AXIS_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RVA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rva check failed");
// Next-cycle implication.
`define RVA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rva check failed");
`endif

### rtl/rva_pkg.sv
// Shared types and constants for the vector rotation block.
package rva_pkg;
  localparam int CompW   = 24;
  localparam int AxisW   = 16;
  localparam int AngW    = 16;
  localparam int Steps   = 16;
  localparam int InW     = 3 * CompW + 3 * AxisW + AngW;
  localparam int OutW    = 3 * CompW;
  localparam int Lat     = Steps + 6;
  localparam logic signed [33:0] Gain = 34'sd652032874;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               neg;
  } cordic_t;

  typedef struct packed {
    logic signed [CompW-1:0] vx, vy, vz;
    logic signed [AxisW-1:0] ax, ay, az;
  } carry_t;

  function automatic logic signed [32:0] atan_c(input int i);
    logic signed [32:0] t;
    unique case (i)
      0: t = 33'sd536870912;  1: t = 33'sd316933406;  2: t = 33'sd167458907;
      3: t = 33'sd85004756;   4: t = 33'sd42667331;   5: t = 33'sd21354465;
      6: t = 33'sd10679838;   7: t = 33'sd5340245;    8: t = 33'sd2670163;
      9: t = 33'sd1335087;    10: t = 33'sd667544;    11: t = 33'sd333772;
      12: t = 33'sd166886;    13: t = 33'sd83443;     14: t = 33'sd41722;
      default: t = 33'sd20861;
    endcase
    return t;
  endfunction
endpackage

### rtl/rva_cordic_cell.sv
// One CORDIC micro-rotation stage with the payload carried beside it.
module rva_cordic_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [3:0]               idx_i,
  input  rva_pkg::cordic_t         c_i,
  input  rva_pkg::carry_t          p_i,
  output rva_pkg::cordic_t         c_o,
  output rva_pkg::carry_t          p_o
);
  import rva_pkg::*;
  cordic_t c_d, c_q;
  carry_t  p_q;
  logic signed [33:0] dx, dy;

  always_comb begin
    dx = c_i.y >>> idx_i;
    dy = c_i.x >>> idx_i;
    c_d = c_i;
    if (!c_i.z[32]) begin
      c_d.x = c_i.x - dx; c_d.y = c_i.y + dy; c_d.z = c_i.z - atan_c(int'(idx_i));
    end else begin
      c_d.x = c_i.x + dx; c_d.y = c_i.y - dy; c_d.z = c_i.z + atan_c(int'(idx_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      p_q <= p_i;
    end
  end
  assign c_o = c_q;
  assign p_o = p_q;
endmodule

### rtl/rva_matmul.sv
// Matrix build and matrix-vector product, registered stage by stage.
module rva_matmul (
  input  logic                         clk_i,
  input  logic [5:0]                   en_i,
  input  rva_pkg::cordic_t             c_i,
  input  rva_pkg::carry_t              p_i,
  output logic [rva_pkg::OutW-1:0]     rot_o,
  output logic                         clip_o
);
  import rva_pkg::*;
  // stage 0: sin/cos, clamp axis
  logic signed [33:0] xn, yn;
  logic signed [19:0] c16_d, s16_d, c16_q, s16_q;
  logic signed [15:0] a_d [3], a_q [3];
  logic signed [CompW-1:0] v0_q [3], v1_q [3], v2_q [3];

  function automatic logic signed [15:0] clampa(input logic signed [AxisW-1:0] a);
    if (a > 16'sd16384) return 16'sd16384;
    if (a < -16'sd16384) return -16'sd16384;
    return a;
  endfunction

  always_comb begin
    xn = c_i.neg ? -c_i.x : c_i.x;
    yn = c_i.neg ? -c_i.y : c_i.y;
    c16_d = 20'((xn + 34'sd8192) >>> 14);
    s16_d = 20'((yn + 34'sd8192) >>> 14);
    a_d[0] = clampa(p_i.ax); a_d[1] = clampa(p_i.ay); a_d[2] = clampa(p_i.az);
  end

  // stage 1: axis products and omc
  logic signed [30:0] aa_q [6];
  logic signed [31:0] as_q [3];
  logic signed [19:0] omc_q, c16b_q;

  // stage 2: entries in 2^-44 units -> Q2.30
  logic signed [48:0] e [9];
  logic signed [34:0] m_q [9];

  // stage 3/4: products, then row sums
  logic signed [59:0] pr_q [9];
  logic signed [61:0] sum_q [3];
  logic [OutW-1:0] rot_d;
  logic clip_d;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      c16_q <= c16_d; s16_q <= s16_d;
      a_q <= a_d;
      v0_q[0] <= p_i.vx; v0_q[1] <= p_i.vy; v0_q[2] <= p_i.vz;
    end
    if (en_i[1]) begin
      aa_q[0] <= 31'(a_q[0]) * 31'(a_q[0]); aa_q[1] <= 31'(a_q[1]) * 31'(a_q[1]);
      aa_q[2] <= 31'(a_q[2]) * 31'(a_q[2]); aa_q[3] <= 31'(a_q[0]) * 31'(a_q[1]);
      aa_q[4] <= 31'(a_q[0]) * 31'(a_q[2]); aa_q[5] <= 31'(a_q[1]) * 31'(a_q[2]);
      for (int i = 0; i < 3; i++) as_q[i] <= 32'(a_q[i]) * 32'(s16_q);
      omc_q  <= 20'sd65536 - c16_q;
      c16b_q <= c16_q;
      v1_q <= v0_q;
    end
    if (en_i[2]) begin
      for (int i = 0; i < 9; i++) m_q[i] <= 35'((e[i] + 49'sd8192) >>> 14);
      v2_q <= v1_q;
    end
    if (en_i[3]) begin
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) pr_q[k*3+j] <= 60'(m_q[k*3+j]) * 60'(v2_q[j]);
    end
    if (en_i[4]) begin
      for (int k = 0; k < 3; k++)
        sum_q[k] <= 62'(pr_q[k*3]) + 62'(pr_q[k*3+1]) + 62'(pr_q[k*3+2]);
    end
    if (en_i[5]) begin
      rot_o  <= rot_d;
      clip_o <= clip_d;
    end
  end

  always_comb begin
    logic signed [48:0] cc, t;
    cc = 49'(c16b_q) <<< 28;
    e[0] = cc + 49'(aa_q[0]) * 49'(omc_q);
    e[4] = cc + 49'(aa_q[1]) * 49'(omc_q);
    e[8] = cc + 49'(aa_q[2]) * 49'(omc_q);
    t = 49'(aa_q[3]) * 49'(omc_q);
    e[1] = t - (49'(as_q[2]) <<< 14); e[3] = t + (49'(as_q[2]) <<< 14);
    t = 49'(aa_q[4]) * 49'(omc_q);
    e[2] = t + (49'(as_q[1]) <<< 14); e[6] = t - (49'(as_q[1]) <<< 14);
    t = 49'(aa_q[5]) * 49'(omc_q);
    e[5] = t - (49'(as_q[0]) <<< 14); e[7] = t + (49'(as_q[0]) <<< 14);
  end

  always_comb begin
    logic signed [61:0] r;
    clip_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r = (sum_q[k] + (62'sd1 <<< 29)) >>> 30;
      if (r > 62'sd8388607) begin
        rot_d[k*CompW +: CompW] = 24'h7FFFFF; clip_d = 1'b1;
      end else if (r < -62'sd8388608) begin
        rot_d[k*CompW +: CompW] = 24'h800000; clip_d = 1'b1;
      end else begin
        rot_d[k*CompW +: CompW] = r[CompW-1:0];
      end
    end
  end
endmodule

### rtl/rotate_vector_about_axis_top.sv
// Top level: Rodrigues rotation with a CORDIC cell chain and a matrix pipeline.
// channel | dir | fields
// s_axis  | in  | tdata: vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle
// m_axis  | out | tdata: rot_x, rot_y, rot_z; tuser: clipped
// One word per cycle while the output is free or taken; 16 CORDIC cells, then 6 matrix/output stages.
// The whole pipe advances when the output is free or taken; it holds on stall.
// Reset clears only the valid bits of the pipe.
`include "rotate_vector_about_axis_top_macros.svh"
module rotate_vector_about_axis_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rva_pkg::InW-1:0]    s_axis_tdata,  // vec_x,vec_y,vec_z,axis_x,axis_y,axis_z,angle
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [rva_pkg::OutW-1:0]   m_axis_tdata,  // rot_x, rot_y, rot_z
  output logic                       m_axis_tuser   // clipped
);
  import rva_pkg::*;
  logic adv;
  logic [Lat-1:0] vld_q;
  cordic_t c [Steps+1];
  carry_t  p [Steps+1];
  logic [31:0] ph;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_comb begin
    ph = {s_axis_tdata[InW-1 -: AngW], {(32-AngW){1'b0}}};
    c[0].neg = ph[31] ^ ph[30];
    if (c[0].neg) ph = ph + 32'h80000000;
    c[0].z = 33'($signed(ph));
    c[0].x = Gain;
    c[0].y = '0;
    p[0] = {s_axis_tdata[0 +: CompW], s_axis_tdata[CompW +: CompW],
            s_axis_tdata[2*CompW +: CompW], s_axis_tdata[3*CompW +: AxisW],
            s_axis_tdata[3*CompW+AxisW +: AxisW], s_axis_tdata[3*CompW+2*AxisW +: AxisW]};
  end

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    rva_cordic_cell u_cell (
      .clk_i, .en_i(adv), .idx_i(4'(g)), .c_i(c[g]), .p_i(p[g]),
      .c_o(c[g+1]), .p_o(p[g+1])
    );
  end

  rva_matmul u_mm (
    .clk_i, .en_i({6{adv}}), .c_i(c[Steps]), .p_i(p[Steps]),
    .rot_o(m_axis_tdata), .clip_o(m_axis_tuser)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end

  `RVA_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `RVA_ASSERT_IMP(a_rdy, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `RVA_ASSERT_NXT(a_flow, s_axis_tvalid && s_axis_tready, vld_q[0])
endmodule

### tb/sv/tb_top.sv
// Testbench for the Rodrigues vector rotation block: random and corner words, checked in order.
`timescale 1ns / 1ps
module tb_top;
  import rva_pkg::*;

  localparam int Period = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  typedef struct packed {
    logic signed [CompW-1:0] rx, ry, rz;
    logic                    clip;
  } rot_t;

  rot_t rot_q[$];
  int   errors = 0;
  bit   stim_done = 1'b0;

  rotate_vector_about_axis_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #(Period / 2) clk_i = ~clk_i;
  end

  function automatic longint clamp_ax(longint a);
    if (a > 16384) return 16384;
    if (a < -16384) return -16384;
    return a;
  endfunction

  // Own arctangent table, phase units of 2^-32 turn.
  function automatic longint atan_tab(int i);
    longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861};
    return t[i];
  endfunction

  // Predict the rotated vector for one input word.
  function automatic rot_t rotate_predict(logic [InW-1:0] w);
    longint v[3], a[3], e[9], m[9], r[3];
    longint x, y, z, dx, dy, c16, s16, omc, cc, maxv, minv, tbl;
    logic [31:0] p;
    logic neg;
    rot_t o;
    logic signed [127:0] sacc;
    neg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(w[i*CompW +: CompW]));
      a[i] = clamp_ax(longint'($signed(w[3*CompW + i*AxisW +: AxisW])));
    end
    p = {w[InW-1 -: AngW], {(32-AngW){1'b0}}};
    if (p[31:30] == 2'b01 || p[31:30] == 2'b10) begin
      p = p + 32'h8000_0000;
      neg = 1'b1;
    end
    z = longint'($signed(p));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      tbl = atan_tab(i);
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= tbl;
      end else begin
        x += dx; y -= dy; z += tbl;
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c16 = (x + 8192) >>> 14;
    s16 = (y + 8192) >>> 14;
    omc = 65536 - c16;
    cc = c16 * 268435456;
    e[0] = cc + a[0]*a[0]*omc;
    e[1] = a[0]*a[1]*omc - a[2]*s16*16384;
    e[2] = a[0]*a[2]*omc + a[1]*s16*16384;
    e[3] = a[0]*a[1]*omc + a[2]*s16*16384;
    e[4] = cc + a[1]*a[1]*omc;
    e[5] = a[1]*a[2]*omc - a[0]*s16*16384;
    e[6] = a[0]*a[2]*omc - a[1]*s16*16384;
    e[7] = a[1]*a[2]*omc + a[0]*s16*16384;
    e[8] = cc + a[2]*a[2]*omc;
    for (int i = 0; i < 9; i++) m[i] = (e[i] + 8192) >>> 14;
    maxv = (longint'(1) << (CompW-1)) - 1;
    minv = -maxv - 1;
    o.clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sacc = 128'sd1 <<< 29;
      for (int j = 0; j < 3; j++) sacc += 128'(signed'(m[3*k+j])) * 128'(signed'(v[j]));
      sacc = sacc >>> 30;
      if (sacc > 128'(signed'(maxv))) begin
        r[k] = maxv; o.clip = 1'b1;
      end else if (sacc < 128'(signed'(minv))) begin
        r[k] = minv; o.clip = 1'b1;
      end else begin
        r[k] = longint'(sacc);
      end
    end
    o.rx = r[0][CompW-1:0];
    o.ry = r[1][CompW-1:0];
    o.rz = r[2][CompW-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic send_word(logic signed [CompW-1:0] vx, vy, vz,
                           logic signed [AxisW-1:0] ax, ay, az,
                           logic [AngW-1:0] ang);
    int gap;
    logic [InW-1:0] w;
    gap = $urandom_range(0, 5);
    if (($urandom % 8) == 0) gap = 0;
    w = {ang, az, ay, ax, vz, vy, vx};
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rot_q.push_back(rotate_predict(w));
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [CompW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CompW-1){1'b0}}};
      1: return {1'b0, {(CompW-1){1'b1}}};
      2: return CompW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return CompW'($urandom);
    endcase
  endfunction

  function automatic logic signed [AxisW-1:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return AxisW'(16384);
      1: return -AxisW'(16384);
      2: return AxisW'($urandom);
      3: return '0;
      default: return AxisW'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [CompW-1:0] vmax, vmin;
    vmax = {1'b0, {(CompW-1){1'b1}}};
    vmin = {1'b1, {(CompW-1){1'b0}}};
    send_word(0, 0, 0, 0, 0, 0, 0);
    send_word(vmax, vmax, vmax, 16384, 0, 0, 0);
    send_word(vmin, vmin, vmin, 0, 16384, 0, 16'h8000);
    send_word(vmax, vmin, vmax, 0, 0, 16384, 16'h4000);
    send_word(vmin, vmax, vmin, 0, 0, -16384, 16'hC000);
    send_word(vmax, vmax, vmin, 16384, 16384, 16384, 16'h2000);
    send_word(32768, -32768, 12345, 16'sh7FFF, 16'sh8000, 100, 16'h7FFF);
    send_word(vmax, vmax, vmax, 9459, 9459, 9459, 16'h1555);
    send_word(32768, 0, 0, 0, 0, 16384, 16'h0001);
    send_word(32768, 0, 0, 0, 0, 16384, 16'hFFFF);
    send_word(vmax, 0, 0, 11585, 11585, 0, 16'h8000);
    send_word(-1, -1, -1, -1, -1, -1, 16'h3FFF);
    send_word(1, 1, 1, 1, 1, 1, 16'h4001);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_word(rand_comp(), rand_comp(), rand_comp(), rand_axis(), rand_axis(),
                rand_axis(), AngW'($urandom));
  endtask

  task automatic test_drain_pause();
    idle_input();
    while (rot_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls, compare each accepted word with the oldest prediction.
  initial begin
    int stall;
    rot_t want;
    @(negedge clk_i);
    forever begin
      stall = $urandom_range(0, 5);
      if (($urandom % 6) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (rot_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = rot_q.pop_front();
        if ($signed(m_axis_tdata[0 +: CompW]) != want.rx)
          report_mismatch("rot_x", $signed(m_axis_tdata[0 +: CompW]), want.rx);
        if ($signed(m_axis_tdata[CompW +: CompW]) != want.ry)
          report_mismatch("rot_y", $signed(m_axis_tdata[CompW +: CompW]), want.ry);
        if ($signed(m_axis_tdata[2*CompW +: CompW]) != want.rz)
          report_mismatch("rot_z", $signed(m_axis_tdata[2*CompW +: CompW]), want.rz);
        if (m_axis_tuser != want.clip)
          report_mismatch("clipped", m_axis_tuser, want.clip);
      end
      @(negedge clk_i);
    end
  end

  initial begin
    #(Period * 400000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int waited;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(900);
    test_drain_pause();
    test_random(1000);
    idle_input();
    waited = 0;
    while (rot_q.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (Lat * 4) @(negedge clk_i);
    if (errors == 0 && rot_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
